// File: hw/rtl/overwriting_byte_ring_buffer_macros.svh
// Assertion macros shared by the ring buffer modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef OVERWRITING_BYTE_RING_BUFFER_MACROS_SVH
`define OVERWRITING_BYTE_RING_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBRB_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obrb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OBRB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obrb assertion failed");

`endif

// File: hw/rtl/obrb_pkg.sv
package obrb_pkg;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 7;
    localparam int LVL_W       = 13;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_FLUSH = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic start_burst;
        logic rd_issue;
        logic out_load_ack;
        logic out_load_data;
        logic out_last;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] burst_len;
        logic             out_valid;
    } dp_status_t;

endpackage

// File: hw/rtl/obrb_ram.sv
module obrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/obrb_ctrl.sv
`include "overwriting_byte_ring_buffer_macros.svh"

module obrb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  obrb_pkg::cmd_t                cmd,
    input  logic                          end_of_chunk,
    input  logic                          m_tready,
    input  obrb_pkg::dp_status_t          status,
    output obrb_pkg::ctrl_cmd_t           ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } state_t;

    state_t                     state_reg;
    logic [obrb_pkg::CNT_W-1:0] iss_cnt_reg;
    logic [obrb_pkg::CNT_W-1:0] emit_cnt_reg;
    logic                       rd_pend_reg;

    logic out_free;
    logic is_rd;
    logic load;
    logic issue;

    always_comb
    begin
        out_free = !status.out_valid || m_tready;
        is_rd    = cmd inside {obrb_pkg::CMD_POP, obrb_pkg::CMD_PEEK};
        s_tready = (state_reg == ST_IDLE) && out_free;
        load     = (state_reg == ST_BURST) && rd_pend_reg && out_free;
        issue    = (state_reg == ST_BURST) && (iss_cnt_reg != '0) && (!rd_pend_reg || load);

        ctl.accept        = s_tvalid && s_tready;
        ctl.start_burst   = ctl.accept && is_rd && (status.burst_len != '0);
        ctl.out_load_ack  = ctl.accept && (((cmd == obrb_pkg::CMD_PUSH) && end_of_chunk) ||
                                           (is_rd && (status.burst_len == '0)));
        ctl.rd_issue      = issue;
        ctl.out_load_data = load;
        ctl.out_last      = (emit_cnt_reg == obrb_pkg::CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iss_cnt_reg  <= '0;
            emit_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (ctl.start_burst)
                    begin
                        state_reg    <= ST_BURST;
                        iss_cnt_reg  <= status.burst_len;
                        emit_cnt_reg <= status.burst_len;
                        rd_pend_reg  <= 1'b0;
                    end
                end
                ST_BURST:
                begin
                    if (issue)
                    begin
                        iss_cnt_reg <= iss_cnt_reg - obrb_pkg::CNT_W'(1);
                    end
                    rd_pend_reg <= issue || (rd_pend_reg && !load);
                    if (load)
                    begin
                        emit_cnt_reg <= emit_cnt_reg - obrb_pkg::CNT_W'(1);
                        if (emit_cnt_reg == obrb_pkg::CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `OBRB_ASSERT_NOW(a_no_read_when_idle, state_reg == ST_IDLE, !ctl.rd_issue && !rd_pend_reg)
    `OBRB_ASSERT_NOW(a_issue_within_emit, state_reg == ST_BURST, iss_cnt_reg <= emit_cnt_reg)
    `OBRB_ASSERT_NOW(a_pend_means_unissued, rd_pend_reg, emit_cnt_reg > iss_cnt_reg)
    `OBRB_ASSERT_NEXT(a_last_returns_idle, ctl.out_load_data && ctl.out_last,
                      state_reg == ST_IDLE)

endmodule

// File: hw/rtl/obrb_dp.sv
`include "overwriting_byte_ring_buffer_macros.svh"

module obrb_dp #(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [obrb_pkg::LVL_W-1:0]       cfg_data,
    input  obrb_pkg::cmd_t                   cmd,
    input  logic [obrb_pkg::BYTE_W-1:0]      data_byte,
    input  logic [obrb_pkg::CNT_W-1:0]       count,
    input  logic [obrb_pkg::LVL_W-1:0]       keep_count,
    input  logic                             m_tready,
    input  obrb_pkg::ctrl_cmd_t              ctl,
    output obrb_pkg::dp_status_t             status,
    output logic                             out_valid,
    output logic [obrb_pkg::BYTE_W-1:0]      out_byte,
    output logic                             out_has,
    output logic                             out_last,
    output logic [obrb_pkg::LVL_W-1:0]       out_fill,
    output logic                             out_drop
);

    localparam int AW      = $clog2(DEPTH);
    localparam int LW      = obrb_pkg::LVL_W;
    localparam int CW      = obrb_pkg::CNT_W;
    localparam int SW      = ((AW > LW) ? AW : LW) + 1;
    localparam int CAP_RST = (DEPTH < 4096) ? DEPTH : 4096;

    // Add within the ring: a < c and b <= c, so one subtract is enough.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [LW-1:0] b,
                                               input logic [LW-1:0] c);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(c))
        begin
            s = s - SW'(c);
        end
        return s[AW-1:0];
    endfunction

    logic [LW-1:0] cap_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] tail_reg;
    logic [LW-1:0] level_reg;
    logic          chunk_drop_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [LW-1:0] fill_reg;
    logic          out_valid_reg;
    logic [obrb_pkg::BYTE_W-1:0] out_byte_reg;
    logic          out_has_reg;
    logic          out_last_reg;
    logic [LW-1:0] out_fill_reg;
    logic          out_drop_reg;

    logic [LW-1:0] cfg_cap;
    logic          full;
    logic [AW-1:0] tail_inc;
    logic [LW-1:0] push_level;
    logic          push_drop;
    logic [CW-1:0] cnt_sat;
    logic [CW-1:0] burst_n;
    logic [AW-1:0] head_pop;
    logic [LW-1:0] level_pop;
    logic          flush_ok;
    logic [AW-1:0] head_flush;
    logic [AW-1:0] rd_ptr_inc;
    logic [LW-1:0] ack_fill;
    logic          ack_drop;
    logic [obrb_pkg::BYTE_W-1:0] ram_rdata;
    logic          is_push;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_cap = LW'(1);
        end
        else if (32'(cfg_data) > DEPTH)
        begin
            cfg_cap = LW'(DEPTH);
        end
        else
        begin
            cfg_cap = cfg_data;
        end

        is_push    = (cmd == obrb_pkg::CMD_PUSH);
        full       = (level_reg == cap_reg);
        tail_inc   = wrap_add(tail_reg, LW'(1), cap_reg);
        push_level = full ? level_reg : level_reg + LW'(1);
        push_drop  = chunk_drop_reg || full;

        cnt_sat    = (count > CW'(MAX_BURST)) ? CW'(MAX_BURST) : count;
        burst_n    = (LW'(cnt_sat) > level_reg) ? level_reg[CW-1:0] : cnt_sat;
        head_pop   = wrap_add(head_reg, LW'(burst_n), cap_reg);
        level_pop  = level_reg - LW'(burst_n);

        flush_ok   = (keep_count < cap_reg) && (keep_count < level_reg);
        head_flush = wrap_add(head_reg, level_reg - keep_count, cap_reg);

        rd_ptr_inc = wrap_add(rd_ptr_reg, LW'(1), cap_reg);

        ack_fill   = is_push ? push_level : level_reg;
        ack_drop   = is_push && push_drop;

        status.burst_len = burst_n;
        status.out_valid = out_valid_reg;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_has   = out_has_reg;
    assign out_last  = out_last_reg;
    assign out_fill  = out_fill_reg;
    assign out_drop  = out_drop_reg;

    obrb_ram #(
        .WIDTH (obrb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.accept && is_push),
        .wr_addr (tail_reg),
        .wr_data (data_byte),
        .rd_en   (ctl.rd_issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    // Ring pointers, fill level and capacity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= LW'(CAP_RST);
            head_reg       <= '0;
            tail_reg       <= '0;
            level_reg      <= '0;
            chunk_drop_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg        <= cfg_cap;
            head_reg       <= '0;
            tail_reg       <= '0;
            level_reg      <= '0;
            chunk_drop_reg <= 1'b0;
        end
        else if (ctl.accept)
        begin
            case (cmd)
                obrb_pkg::CMD_PUSH:
                begin
                    tail_reg  <= tail_inc;
                    level_reg <= push_level;
                    if (full)
                    begin
                        head_reg <= tail_inc;
                    end
                    chunk_drop_reg <= ctl.out_load_ack ? 1'b0 : push_drop;
                end
                obrb_pkg::CMD_POP:
                begin
                    head_reg  <= head_pop;
                    level_reg <= level_pop;
                end
                obrb_pkg::CMD_FLUSH:
                begin
                    if (flush_ok)
                    begin
                        if (keep_count == '0)
                        begin
                            head_reg  <= '0;
                            tail_reg  <= '0;
                            level_reg <= '0;
                        end
                        else
                        begin
                            head_reg  <= head_flush;
                            level_reg <= keep_count;
                        end
                    end
                end
                obrb_pkg::CMD_CLEAR:
                begin
                    head_reg       <= '0;
                    tail_reg       <= '0;
                    level_reg      <= '0;
                    chunk_drop_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load_ack || ctl.out_load_data)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Burst read pointer, burst fill value and output payload.
    always_ff @(posedge clk)
    begin
        if (ctl.start_burst)
        begin
            rd_ptr_reg <= head_reg;
            fill_reg   <= (cmd == obrb_pkg::CMD_POP) ? level_pop : level_reg;
        end
        else if (ctl.rd_issue)
        begin
            rd_ptr_reg <= rd_ptr_inc;
        end

        if (ctl.out_load_ack)
        begin
            out_byte_reg <= '0;
            out_has_reg  <= 1'b0;
            out_last_reg <= 1'b1;
            out_fill_reg <= ack_fill;
            out_drop_reg <= ack_drop;
        end
        else if (ctl.out_load_data)
        begin
            out_byte_reg <= ram_rdata;
            out_has_reg  <= 1'b1;
            out_last_reg <= ctl.out_last;
            out_fill_reg <= fill_reg;
            out_drop_reg <= 1'b0;
        end
    end

    `OBRB_ASSERT_NOW(a_level_in_cap, 1'b1, level_reg <= cap_reg)
    `OBRB_ASSERT_NOW(a_ptrs_in_cap, 1'b1,
                     (SW'(head_reg) < SW'(cap_reg)) && (SW'(tail_reg) < SW'(cap_reg)))
    `OBRB_ASSERT_NOW(a_full_or_empty_aligned, (level_reg == cap_reg) || (level_reg == '0),
                     head_reg == tail_reg)
    `OBRB_ASSERT_NOW(a_single_load, 1'b1, !(ctl.out_load_ack && ctl.out_load_data))

endmodule

// File: hw/rtl/overwriting_byte_ring_buffer.sv
// Byte ring buffer that overwrites its oldest byte when full. Requests enter on the s_ stream
// and results leave on the m_ stream. A chunk of pushes streams in at one byte per clock while
// no result waits on m_tready; only a push marked with tlast returns a result (the fill level
// and whether any byte of that chunk overwrote old data). A pop or peek of n bytes (count
// saturated to MAX_BURST and to the fill level) streams them out through the memory's registered
// read port at one per clock while m_tready does not hold the result stream; the next request
// is taken only after the burst ends. With nothing to give, it returns a single empty result.
// Flush, clear and unused command codes return nothing. A write on the cfg_ port sets the
// capacity (0 acts as 1, values above DEPTH act as DEPTH) and empties the buffer; write it only
// while no request is in progress. Storage is one DEPTH x 8 memory with one write and one read
// port; it needs no clearing after reset, since only bytes written since the buffer was last
// emptied are ever read.
module overwriting_byte_ring_buffer #(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Request stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata from bit 0: data_byte[7:0], count[14:8], keep_count[27:15], zero [31:28].
    input  logic [obrb_pkg::IN_TDATA_W-1:0]       s_tdata,
    // s_tuser from bit 0: cmd[2:0].
    input  logic [obrb_pkg::CMD_W-1:0]            s_tuser,
    // s_tlast: end_of_chunk.
    input  logic                                  s_tlast,

    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata from bit 0: out_byte[7:0], fill_level[20:8], zero [23:21].
    output logic [obrb_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // m_tuser from bit 0: has_byte[0], dropped[1].
    output logic [obrb_pkg::OUT_TUSER_W-1:0]      m_tuser,
    // m_tlast: last result of the request.
    output logic                                  m_tlast,

    // Capacity register write.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [obrb_pkg::LVL_W-1:0]            cfg_data
);

    obrb_pkg::cmd_t                    cmd;
    logic [obrb_pkg::BYTE_W-1:0]       data_byte;
    logic [obrb_pkg::CNT_W-1:0]        count;
    logic [obrb_pkg::LVL_W-1:0]        keep_count;
    obrb_pkg::ctrl_cmd_t               ctl;
    obrb_pkg::dp_status_t              status;
    logic [obrb_pkg::BYTE_W-1:0]       out_byte;
    logic                              out_has;
    logic [obrb_pkg::LVL_W-1:0]        out_fill;
    logic                              out_drop;

    // Unpack the request fields.
    assign cmd        = obrb_pkg::cmd_t'(s_tuser);
    assign data_byte  = s_tdata[7:0];
    assign count      = s_tdata[14:8];
    assign keep_count = s_tdata[27:15];

    // The controller sequences the request handshake and the read bursts.
    obrb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .cmd          (cmd),
        .end_of_chunk (s_tlast),
        .m_tready     (m_tready),
        .status       (status),
        .ctl          (ctl)
    );

    // The datapath holds the ring pointers, the memory and the output register.
    obrb_dp #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .count      (count),
        .keep_count (keep_count),
        .m_tready   (m_tready),
        .ctl        (ctl),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_byte   (out_byte),
        .out_has    (out_has),
        .out_last   (m_tlast),
        .out_fill   (out_fill),
        .out_drop   (out_drop)
    );

    // Pack the result fields.
    assign m_tdata = {3'b000, out_fill, out_byte};
    assign m_tuser = {out_drop, out_has};

endmodule
